@@ rtl/core/vfd_pkg.sv @@
// Shared constants, queue command type and character codes for the frame deframer.
package vfd_pkg;

    localparam int MAX_FRAME_LEN = 40;
    localparam int LEN_W         = 6;
    localparam int ADDR_W        = 12;
    localparam int CTRL_W        = 4;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 8;
    localparam int QPTR_W        = 2;
    localparam int HDR_BYTES     = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 8'd1;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 6'd40;

    localparam logic [7:0] END_PLAIN = 8'hEE;
    localparam logic [7:0] END_ACK   = 8'hEF;

    // control nibble bits
    localparam int CTRL_EXT = 3;
    localparam int CTRL_RAK = 2;
    localparam int CTRL_RNW = 1;
    localparam int CTRL_RTR = 0;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UA    = 7'h41;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_R     = 7'h52;
    localparam logic [6:0] CH_W     = 7'h57;
    localparam logic [6:0] CH_T     = 7'h54;

    // one queue entry: either a data byte write or a finished good frame
    typedef struct packed {
        logic              is_frame;
        logic [7:0]        data;
        logic [LEN_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [CTRL_W-1:0] ctrl;
        logic [LEN_W-1:0]  len;
        logic              end_ack;
    } vfd_cmd_t;

endpackage

@@ rtl/core/van_frame_deframer_hex_text_top.sv @@
// Top level of the frame deframer with hex text output.
//
// Bytes captured from the bus enter on the s_ channel, one per beat. A good
// frame of length n (n+4 bytes) is answered by n+4 beats on the m_ channel,
// each carrying two ASCII characters; m_last_of_frame marks the final beat.
// Dropped frames and bytes taken while enable is clear give no beats.
// Configuration: cfg_index 0 is enable (bit 0), index 1 is length_limit
// (bits 5:0); cfg_ready is always high; write only while the block is idle.
// The parser takes one byte per cycle while the four-entry command queue has
// room. The emitter pops one data byte write per cycle into the 40-byte store
// while no frame is in flight and, for a frame, reads the store through one
// registered port, giving one beat per cycle while m_ready is high. The end
// byte's command passes the queue, the busy stage, stage one and the output
// register; no command is popped until the frame's last pair leaves stage one.
// Reset clears the parser, queue and emitter; enable resets to 0 and
// length_limit to 40. A stalled m_ready holds the output beat and the
// emitter; the queue then fills and s_ready drops.
module van_frame_deframer_hex_text_top
    import vfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [6:0]            m_char_first,
    output logic [6:0]            m_char_second,
    output logic                  m_last_of_frame,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic     q_full;
    logic     q_push;
    vfd_cmd_t q_push_cmd;
    logic     q_valid;
    logic     q_ready;
    vfd_cmd_t q_head;

    vfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    vfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .head_valid (q_valid),
        .pop_ready  (q_ready),
        .head_cmd   (q_head)
    );

    vfd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_cmd           (q_head),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_first    (m_char_first),
        .m_char_second   (m_char_second),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

@@ rtl/core/vfd_front.sv @@
// Front end: configuration registers and header/data/end-byte parser feeding the queue.
module vfd_front
    import vfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  q_push,
    output vfd_cmd_t              q_cmd
);

    logic              enable_reg;
    logic [LEN_W-1:0]  limit_reg;
    logic [LEN_W-1:0]  byte_count_reg, byte_count_next;
    logic [LEN_W-1:0]  frame_length_reg, frame_length_next;
    logic [ADDR_W-1:0] frame_address_reg, frame_address_next;
    logic [CTRL_W-1:0] control_bits_reg, control_bits_next;

    logic              accept;
    logic [LEN_W-1:0]  lim;
    logic [LEN_W-1:0]  data_idx;
    logic              hdr_bad;
    logic              end_ok;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign lim      = (limit_reg < LEN_W'(MAX_FRAME_LEN)) ? limit_reg : LEN_W'(MAX_FRAME_LEN);
    assign data_idx = byte_count_reg - LEN_W'(HDR_BYTES);
    assign hdr_bad  = (s_rx_byte != 8'd0) || (frame_address_reg == '0) ||
                      (frame_length_reg == '0) || !control_bits_reg[CTRL_EXT];
    assign end_ok   = (s_rx_byte == END_PLAIN) || (s_rx_byte == END_ACK);

    always_comb begin
        byte_count_next    = byte_count_reg;
        frame_length_next  = frame_length_reg;
        frame_address_next = frame_address_reg;
        control_bits_next  = control_bits_reg;
        q_push             = 1'b0;
        q_cmd.is_frame     = 1'b0;
        q_cmd.data         = s_rx_byte;
        q_cmd.idx          = data_idx;
        q_cmd.addr         = frame_address_reg;
        q_cmd.ctrl         = control_bits_reg;
        q_cmd.len          = frame_length_reg;
        q_cmd.end_ack      = (s_rx_byte == END_ACK);
        if (accept && enable_reg) begin
            if (byte_count_reg < LEN_W'(HDR_BYTES)) begin
                byte_count_next = byte_count_reg + 1'b1;
                unique case (byte_count_reg[1:0])
                    2'd0: frame_address_next = {s_rx_byte, 4'h0};
                    2'd1: begin
                        frame_address_next = {frame_address_reg[ADDR_W-1:4], s_rx_byte[7:4]};
                        control_bits_next  = s_rx_byte[3:0];
                    end
                    2'd2: begin
                        frame_length_next = ((s_rx_byte != 8'd0) && (s_rx_byte <= {2'b00, lim}))
                                            ? s_rx_byte[LEN_W-1:0] : '0;
                    end
                    2'd3: begin
                        if (hdr_bad) begin
                            byte_count_next   = '0;
                            frame_length_next = '0;
                        end
                    end
                    default: ;
                endcase
            end else if (frame_length_reg == '0) begin
                byte_count_next   = '0;
                frame_length_next = '0;
            end else if (({1'b0, data_idx} + 7'd1) < {1'b0, frame_length_reg}) begin
                // data byte: hand it to the back end for storage
                q_push          = 1'b1;
                byte_count_next = byte_count_reg + 1'b1;
            end else begin
                q_push            = end_ok;
                q_cmd.is_frame    = 1'b1;
                byte_count_next   = '0;
                frame_length_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= 1'b0;
            limit_reg         <= LIMIT_RESET;
            byte_count_reg    <= '0;
            frame_length_reg  <= '0;
            frame_address_reg <= '0;
            control_bits_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ENABLE) begin
                    enable_reg <= cfg_data[0];
                end else if (cfg_index == CFG_LENGTH_LIMIT) begin
                    limit_reg <= cfg_data[LEN_W-1:0];
                end
            end
            byte_count_reg    <= byte_count_next;
            frame_length_reg  <= frame_length_next;
            frame_address_reg <= frame_address_next;
            control_bits_reg  <= control_bits_next;
        end
    end

endmodule

@@ rtl/core/vfd_queue.sv @@
// Short command queue between the parser and the text emitter.
module vfd_queue
    import vfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  vfd_cmd_t push_cmd,
    output logic     full,
    output logic     head_valid,
    input  logic     pop_ready,
    output vfd_cmd_t head_cmd
);

    localparam int QDEPTH = 1 << QPTR_W;

    vfd_cmd_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              pop;

    assign full       = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

@@ rtl/core/vfd_back.sv @@
// Back end: data byte store and two-stage hex text emitter with output register.
module vfd_back
    import vfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  vfd_cmd_t   q_cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_char_first,
    output logic [6:0] m_char_second,
    output logic       m_last_of_frame
);

    function automatic logic [6:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (CH_ZERO + 7'(v)) : (CH_UA + 7'(v - 4'd10));
    endfunction

    logic [7:0]        mem [MAX_FRAME_LEN];
    logic [7:0]        rd_data_reg;

    logic              busy_reg;
    logic [LEN_W-1:0]  k0_reg;
    logic              valid1_reg;
    logic [LEN_W-1:0]  k1_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CTRL_W-1:0] ctrl_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              end_ack_reg;

    logic              m_valid_reg;
    logic [6:0]        first_reg;
    logic [6:0]        second_reg;
    logic              last_reg;

    logic              adv;
    logic              pop;
    logic [LEN_W-1:0]  last_k;
    logic [LEN_W-1:0]  rd_idx;
    logic [6:0]        first_next;
    logic [6:0]        second_next;

    assign adv     = !m_valid_reg || m_ready;
    // hold the descriptor until the last pair has left stage one
    assign pop     = q_valid && !busy_reg && !valid1_reg;
    assign q_ready = pop;
    assign last_k  = len_reg + LEN_W'(3);
    assign rd_idx  = (k0_reg >= LEN_W'(HDR_BYTES)) ? (k0_reg - LEN_W'(HDR_BYTES)) : '0;

    always_comb begin
        first_next  = hex_char(rd_data_reg[7:4]);
        second_next = hex_char(rd_data_reg[3:0]);
        if (k1_reg == LEN_W'(0)) begin
            first_next  = hex_char(addr_reg[11:8]);
            second_next = hex_char(addr_reg[7:4]);
        end else if (k1_reg == LEN_W'(1)) begin
            first_next  = hex_char(addr_reg[3:0]);
            second_next = CH_SPACE;
        end else if (k1_reg == LEN_W'(2)) begin
            first_next  = ctrl_reg[CTRL_RNW] ? CH_R : CH_W;
            second_next = ctrl_reg[CTRL_RAK] ? CH_UA : CH_DASH;
        end else if (k1_reg == LEN_W'(3)) begin
            first_next  = ctrl_reg[CTRL_RTR] ? CH_T : CH_DASH;
            second_next = CH_SPACE;
        end else if (k1_reg == last_k) begin
            first_next  = CH_SPACE;
            second_next = end_ack_reg ? CH_UA : CH_DASH;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && !q_cmd.is_frame) begin
            mem[q_cmd.idx] <= q_cmd.data;
        end
        if (adv && busy_reg) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            valid1_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            k0_reg      <= '0;
        end else begin
            if (pop && q_cmd.is_frame) begin
                busy_reg    <= 1'b1;
                k0_reg      <= '0;
                addr_reg    <= q_cmd.addr;
                ctrl_reg    <= q_cmd.ctrl;
                len_reg     <= q_cmd.len;
                end_ack_reg <= q_cmd.end_ack;
            end
            if (adv) begin
                valid1_reg  <= busy_reg;
                m_valid_reg <= valid1_reg;
                if (busy_reg) begin
                    k1_reg <= k0_reg;
                    k0_reg <= k0_reg + 1'b1;
                    if (k0_reg == last_k) begin
                        busy_reg <= 1'b0;
                    end
                end
                if (valid1_reg) begin
                    first_reg  <= first_next;
                    second_reg <= second_next;
                    last_reg   <= (k1_reg == last_k);
                end
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_char_first    = first_reg;
    assign m_char_second   = second_reg;
    assign m_last_of_frame = last_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_cmd.is_frame) |=> busy_reg)
        else $error("frame popped but emitter not started");

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (k0_reg <= last_k))
        else $error("pair counter ran past end of line");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !q_ready)
        else $error("queue popped while emitting");

endmodule
